[design/brb_pkg.sv]
package brb_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned AMOUNT_W = 13;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned COUNT_W  = 12;

  typedef enum logic [1:0] {
    FUNC_PUT     = 2'd0,
    FUNC_PEEK    = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } brb_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ERROR    = 2'd2
  } brb_status_t;

endpackage

[design/brb_if.sv]
// Request channel into the ring buffer.
interface brb_in_if;
  logic                            valid;
  logic                            ready;
  brb_pkg::brb_func_t              func;
  logic [brb_pkg::DATA_W-1:0]      data_in;
  logic                            chunk_start;
  logic [brb_pkg::AMOUNT_W-1:0]    amount;
  logic [brb_pkg::OFFSET_W-1:0]    offset;

  modport source (output valid, func, data_in, chunk_start, amount, offset, input ready);
  modport sink   (input valid, func, data_in, chunk_start, amount, offset, output ready);
endinterface

// Result channel out of the ring buffer.
interface brb_out_if;
  logic                            valid;
  logic                            ready;
  logic [brb_pkg::DATA_W-1:0]      read_data;
  brb_pkg::brb_status_t            status;
  logic [brb_pkg::COUNT_W-1:0]     valid_count;
  logic                            not_empty;

  modport source (output valid, read_data, status, valid_count, not_empty, input ready);
  modport sink   (input valid, read_data, status, valid_count, not_empty, output ready);
endinterface

[design/brb_store.sv]
// Byte store: one write port, one read port, registered read data.
module brb_store #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [brb_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [brb_pkg::DATA_W-1:0] rd_data
);

  logic [brb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [brb_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/byte_ring_buffer_unit.sv]
// Byte ring buffer that keeps one slot empty, so it holds at most BUFFER_DEPTH-1 bytes
// between a head pointer (oldest byte) and a tail pointer (next free slot). Each
// request is one of put byte, peek byte, advance head or clear, and gives exactly one
// result carrying the peeked byte, a status, the stored byte count and a not-empty
// flag. A put chunk is judged as a whole on its first byte: a zero length is an error,
// and a length that does not fit the free space drops the whole chunk with a no-space
// status on every one of its bytes. The unit takes one request per clock cycle unless
// its result is stalled: the pointers and chunk bookkeeping update in the cycle a
// request is taken, a put writes its byte in that same cycle, and a peek reads the
// byte store in that cycle so the byte lands in the result in the following cycle,
// together with the rest of the result. A request is taken whenever the result
// register is empty or being drained. The byte store needs no clearing after reset;
// a peek only reaches bytes that a put has stored.
module byte_ring_buffer_unit #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  brb_in_if.sink    in_chan,
  brb_out_if.source out_chan
);

  // Pointer width, and a wider width in which all length and count math fits.
  localparam int unsigned PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = ((PW > brb_pkg::AMOUNT_W) ? PW : brb_pkg::AMOUNT_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  // Architectural state.
  logic [PW-1:0]                  head_r, head_nxt;
  logic [PW-1:0]                  tail_r, tail_nxt;
  logic [brb_pkg::AMOUNT_W-1:0]   rem_r, rem_nxt;
  logic                           drop_r, drop_nxt;

  // Result register.
  logic                           out_valid_r;
  brb_pkg::brb_status_t           out_status_r, status_nxt;
  logic [brb_pkg::COUNT_W-1:0]    out_count_r;
  logic                           out_not_empty_r;
  logic                           rd_sel_r, rd_sel_nxt;

  // Store access.
  logic                           mem_we;
  logic                           mem_re;
  logic [PW-1:0]                  mem_raddr;
  logic [brb_pkg::DATA_W-1:0]     mem_rdata;

  logic                           accept;
  logic [CW-1:0]                  count_w;
  logic [CW-1:0]                  free_w;
  logic [CW-1:0]                  amount_w;
  logic [CW-1:0]                  offset_w;
  logic [CW-1:0]                  head_sum;
  logic [CW-1:0]                  peek_sum;
  logic [CW-1:0]                  count_nxt;
  logic [PW-1:0]                  tail_inc;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Bytes stored now, and free slots counting the one that always stays empty.
  assign count_w  = (tail_r >= head_r) ? CW'(tail_r) - CW'(head_r)
                                       : CW'(tail_r) + DEPTH_C - CW'(head_r);
  assign free_w   = DEPTH_C - count_w;
  assign amount_w = CW'(in_chan.amount);
  assign offset_w = CW'(in_chan.offset);

  // Where they are used, both sums stay below twice the depth, so one subtract wraps them.
  assign head_sum = CW'(head_r) + amount_w;
  assign peek_sum = CW'(head_r) + offset_w;
  assign tail_inc = (CW'(tail_r) == DEPTH_C - CW'(1)) ? '0 : tail_r + PW'(1);

  assign mem_raddr = (peek_sum >= DEPTH_C) ? PW'(peek_sum - DEPTH_C) : PW'(peek_sum);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    rem_nxt    = rem_r;
    drop_nxt   = drop_r;
    status_nxt = brb_pkg::ST_OK;
    rd_sel_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    if (accept) begin
      unique case (in_chan.func)
        brb_pkg::FUNC_PUT: begin
          if (in_chan.chunk_start) begin
            // A new chunk start abandons whatever chunk was open.
            rem_nxt  = '0;
            drop_nxt = 1'b0;
            if (in_chan.amount == '0) begin
              status_nxt = brb_pkg::ST_ERROR;
            end else if (amount_w >= free_w) begin
              status_nxt = brb_pkg::ST_NO_SPACE;
              drop_nxt   = 1'b1;
              rem_nxt    = in_chan.amount - brb_pkg::AMOUNT_W'(1);
            end else begin
              mem_we   = 1'b1;
              tail_nxt = tail_inc;
              rem_nxt  = in_chan.amount - brb_pkg::AMOUNT_W'(1);
            end
          end else if (rem_r == '0) begin
            status_nxt = brb_pkg::ST_ERROR;
          end else begin
            rem_nxt = rem_r - brb_pkg::AMOUNT_W'(1);
            if (drop_r) begin
              status_nxt = brb_pkg::ST_NO_SPACE;
            end else if (count_w >= DEPTH_C - CW'(1)) begin
              status_nxt = brb_pkg::ST_NO_SPACE;
            end else begin
              mem_we   = 1'b1;
              tail_nxt = tail_inc;
            end
            if (rem_r == brb_pkg::AMOUNT_W'(1)) begin
              drop_nxt = 1'b0;
            end
          end
        end
        brb_pkg::FUNC_PEEK: begin
          if (offset_w >= count_w) begin
            status_nxt = brb_pkg::ST_ERROR;
          end else begin
            mem_re     = 1'b1;
            rd_sel_nxt = 1'b1;
          end
        end
        brb_pkg::FUNC_ADVANCE: begin
          if (amount_w > count_w) begin
            status_nxt = brb_pkg::ST_ERROR;
          end else begin
            head_nxt = (head_sum >= DEPTH_C) ? PW'(head_sum - DEPTH_C) : PW'(head_sum);
          end
        end
        brb_pkg::FUNC_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          rem_nxt  = '0;
          drop_nxt = 1'b0;
        end
        default: begin
          status_nxt = brb_pkg::ST_ERROR;
        end
      endcase
    end
  end

  // Count after the operation, reported in its low bits.
  assign count_nxt = (tail_nxt >= head_nxt) ? CW'(tail_nxt) - CW'(head_nxt)
                                            : CW'(tail_nxt) + DEPTH_C - CW'(head_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      rem_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      rem_r  <= rem_nxt;
      drop_r <= drop_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status_nxt;
      out_count_r     <= count_nxt[brb_pkg::COUNT_W-1:0];
      out_not_empty_r <= (head_nxt != tail_nxt);
      rd_sel_r        <= rd_sel_nxt;
    end
  end

  brb_store #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (tail_r),
    .wr_data (in_chan.data_in),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // The store read data is held until the next peek, which cannot be taken before
  // this result leaves, so it pairs with the registered result fields.
  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_data   = rd_sel_r ? mem_rdata : '0;
  assign out_chan.status      = out_status_r;
  assign out_chan.valid_count = out_count_r;
  assign out_chan.not_empty   = out_not_empty_r;

  // A byte is never written into the slot that must stay empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (count_w < DEPTH_C - CW'(1)))
    else $error("byte stored into a full buffer");

  // Continuation bytes of a dropped chunk are never stored.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.func == brb_pkg::FUNC_PUT) && !in_chan.chunk_start && drop_r)
      |-> !mem_we)
    else $error("byte of a dropped chunk was stored");

  // Pointers stay inside the buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r) < DEPTH_C) && (CW'(tail_r) < DEPTH_C))
    else $error("pointer out of range");

  // A clear leaves an empty buffer with no open chunk.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.func == brb_pkg::FUNC_CLEAR)) |=>
      ((head_r == '0) && (tail_r == '0) && (rem_r == '0) && !drop_r))
    else $error("clear did not empty the buffer");

  // Only a successful peek returns a byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rd_sel_r) |-> (out_status_r == brb_pkg::ST_OK))
    else $error("peek data returned with a failing status");

endmodule

[sim/tb.sv]
module tb;

  // Depth of the ring under test; the predictor and the stimulus both rely on it.
  localparam int unsigned DEPTH       = 4096;
  // The run is cut off here if results stop coming.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Results are registered after their request; these cycles cover the tail of the run.
  localparam int unsigned TAIL_CYCLES = 8;

  // One request into the ring and one result out of it, at the widths of the ports.
  typedef struct packed {
    brb_pkg::brb_func_t           func;
    logic [brb_pkg::DATA_W-1:0]   data;
    logic                         start;
    logic [brb_pkg::AMOUNT_W-1:0] amount;
    logic [brb_pkg::OFFSET_W-1:0] offset;
  } ring_req_t;

  typedef struct packed {
    logic [brb_pkg::DATA_W-1:0]  read_data;
    brb_pkg::brb_status_t        status;
    logic [brb_pkg::COUNT_W-1:0] count;
    logic                        not_empty;
  } ring_result_t;

  // Ways the result side may behave for a stretch of cycles.
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_BURSTY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  brb_in_if  in_chan();
  brb_out_if out_chan();

  byte_ring_buffer_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Shadow copy of the ring. It is updated at the edge where a request is taken, in the
  // same order as the block sees the requests.
  logic [brb_pkg::DATA_W-1:0]   ring_bytes [DEPTH];
  logic [brb_pkg::COUNT_W-1:0]  ring_head;
  logic [brb_pkg::COUNT_W-1:0]  ring_tail;
  logic [brb_pkg::AMOUNT_W-1:0] chunk_left;
  logic                         chunk_drop;

  // Results that the block still owes us, oldest first.
  ring_result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned requests_sent  = 0;
  int unsigned cycle_count    = 0;

  // Sender burst bookkeeping: requests left in the current burst, and whether valid is
  // currently being held high by the sender.
  int unsigned burst_left = 0;
  bit          in_driving = 1'b0;

  function automatic int unsigned stored_bytes();
    logic [brb_pkg::COUNT_W-1:0] diff;
    diff = ring_tail - ring_head;
    return 32'(diff);
  endfunction

  function automatic void push_ring_byte(input logic [brb_pkg::DATA_W-1:0] b);
    ring_bytes[ring_tail] = b;
    ring_tail = ring_tail + 1'b1;
  endfunction

  // Works out the result of one request and moves the shadow ring along with it.
  function automatic ring_result_t predict_ring_result(input ring_req_t r);
    ring_result_t res;
    int unsigned  fill;
    fill          = stored_bytes();
    res.read_data = '0;
    res.status    = brb_pkg::ST_OK;
    case (r.func)
      brb_pkg::FUNC_PUT: begin
        if (r.start) begin
          // A new chunk always drops whatever chunk was still open.
          chunk_left = '0;
          chunk_drop = 1'b0;
          if (r.amount == 0) begin
            res.status = brb_pkg::ST_ERROR;
          end else if (r.amount >= DEPTH - fill) begin
            // The chunk does not fit: it and all its remaining bytes are discarded.
            res.status = brb_pkg::ST_NO_SPACE;
            chunk_drop = 1'b1;
            chunk_left = r.amount - 1'b1;
          end else begin
            push_ring_byte(r.data);
            chunk_left = r.amount - 1'b1;
          end
        end else if (chunk_left == 0) begin
          res.status = brb_pkg::ST_ERROR;
        end else begin
          chunk_left = chunk_left - 1'b1;
          if (chunk_drop) begin
            res.status = brb_pkg::ST_NO_SPACE;
          end else if (fill >= DEPTH - 1) begin
            res.status = brb_pkg::ST_NO_SPACE;
          end else begin
            push_ring_byte(r.data);
          end
          if (chunk_left == 0) chunk_drop = 1'b0;
        end
      end
      brb_pkg::FUNC_PEEK: begin
        if (r.offset >= fill) begin
          res.status = brb_pkg::ST_ERROR;
        end else begin
          res.read_data = ring_bytes[brb_pkg::COUNT_W'(ring_head + r.offset)];
        end
      end
      brb_pkg::FUNC_ADVANCE: begin
        if (r.amount > fill) begin
          res.status = brb_pkg::ST_ERROR;
        end else begin
          ring_head = brb_pkg::COUNT_W'(ring_head + r.amount);
        end
      end
      default: begin
        ring_head  = '0;
        ring_tail  = '0;
        chunk_left = '0;
        chunk_drop = 1'b0;
      end
    endcase
    res.count     = ring_tail - ring_head;
    res.not_empty = (ring_head != ring_tail);
    return res;
  endfunction

  function automatic ring_req_t make_req(input brb_pkg::brb_func_t f,
                                         input logic [brb_pkg::DATA_W-1:0] d,
                                         input logic s,
                                         input logic [brb_pkg::AMOUNT_W-1:0] a,
                                         input logic [brb_pkg::OFFSET_W-1:0] o);
    ring_req_t r;
    r.func   = f;
    r.data   = d;
    r.start  = s;
    r.amount = a;
    r.offset = o;
    return r;
  endfunction

  function automatic logic [brb_pkg::AMOUNT_W-1:0] random_amount();
    return brb_pkg::AMOUNT_W'($urandom_range(0, DEPTH));
  endfunction

  // Sends one request and returns at the edge where the block took it. Requests come in
  // bursts of random length; between bursts valid may drop for a random number of cycles.
  // Within a burst valid stays high and only the payload changes, so valid is never
  // lowered and raised in the same step. The caller is always at a rising edge here.
  task automatic send_request(input ring_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        if (in_driving) in_chan.valid <= 1'b0;
        in_driving = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.func        <= r.func;
    in_chan.data_in     <= r.data;
    in_chan.chunk_start <= r.start;
    in_chan.amount      <= r.amount;
    in_chan.offset      <= r.offset;
    in_chan.valid       <= 1'b1;
    in_driving = 1'b1;
    // Ready is looked at in the middle of the cycle, where nothing is changing; if it is
    // high there, the request is taken at the next rising edge.
    do @(negedge clk); while (in_chan.ready !== 1'b1);
    @(posedge clk);
    pending_results.push_back(predict_ring_result(r));
    requests_sent++;
  endtask

  // Lowers valid when the sender is about to do something other than send. It waits for a
  // rising edge so that the next request cannot raise valid in the same step.
  task automatic release_input();
    if (in_driving) begin
      in_chan.valid <= 1'b0;
      in_driving = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One request of each kind. Fields that the operation ignores are filled at random so
  // that they still toggle.
  task automatic put_byte(input logic start, input logic [brb_pkg::AMOUNT_W-1:0] amount,
                          input logic [brb_pkg::DATA_W-1:0] data);
    send_request(make_req(brb_pkg::FUNC_PUT, data, start, amount,
                          brb_pkg::OFFSET_W'($urandom)));
  endtask

  task automatic peek_at(input logic [brb_pkg::OFFSET_W-1:0] offset);
    send_request(make_req(brb_pkg::FUNC_PEEK, brb_pkg::DATA_W'($urandom), 1'($urandom),
                          random_amount(), offset));
  endtask

  task automatic advance_by(input logic [brb_pkg::AMOUNT_W-1:0] amount);
    send_request(make_req(brb_pkg::FUNC_ADVANCE, brb_pkg::DATA_W'($urandom), 1'($urandom),
                          amount, brb_pkg::OFFSET_W'($urandom)));
  endtask

  task automatic clear_ring();
    send_request(make_req(brb_pkg::FUNC_CLEAR, brb_pkg::DATA_W'($urandom), 1'($urandom),
                          random_amount(), brb_pkg::OFFSET_W'($urandom)));
  endtask

  // Peek, advance and a zero-length put against an empty ring, and a put byte with no chunk to belong to.
  task automatic test_empty_ring_errors();
    peek_at(12'd0);
    advance_by(13'd0);
    advance_by(13'd1);
    put_byte(1'b0, 13'd5, 8'h3C);
    put_byte(1'b1, 13'd0, 8'hC3);
    release_input();
  endtask

  // A chunk too large for the free space is dropped byte by byte until a new chunk
  // start replaces it. The accepted chunk is then read back, around its edges too.
  task automatic test_chunk_accept_reject();
    put_byte(1'b1, 13'd4096, 8'hFF);
    put_byte(1'b0, 13'd0, 8'h11);
    put_byte(1'b1, 13'd3, 8'h00);
    put_byte(1'b0, 13'd4096, 8'hA5);
    put_byte(1'b0, 13'd1, 8'h5A);
    peek_at(12'd0);
    peek_at(12'd1);
    peek_at(12'd2);
    peek_at(12'd3);
    peek_at(12'd4095);
    advance_by(13'd4);
    advance_by(13'd1);
    release_input();
  endtask

  // Clear drops an open chunk. Then the chunk length is tried right at the free-space
  // limit: one below it fits, equal to it does not.
  task automatic test_clear_and_space_limit();
    put_byte(1'b1, 13'd4, 8'h81);
    put_byte(1'b0, 13'd4, 8'h7E);
    clear_ring();
    put_byte(1'b0, 13'd2, 8'h42);
    put_byte(1'b1, 13'(DEPTH - 1), 8'h99);
    put_byte(1'b1, 13'(DEPTH - 2), 8'h66);
    put_byte(1'b1, 13'(DEPTH - 2), 8'hE7);
    clear_ring();
    release_input();
  endtask

  // Mostly well-formed traffic: whole chunks, peeks inside the stored bytes, small
  // advances. Mixed in are abandoned chunks, chunk lengths at the free-space limit,
  // clears and out-of-range or fully random requests.
  task automatic test_random_traffic(input int unsigned n_requests);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    int unsigned sent_len;
    int unsigned fill;
    int unsigned free_slots;
    int unsigned i;
    target = requests_sent + n_requests;
    while (requests_sent < target) begin
      pick       = $urandom_range(0, 99);
      fill       = stored_bytes();
      free_slots = DEPTH - fill;
      if (pick < 40) begin
        len      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                               : $urandom_range(1, 12);
        // Now and then the chunk is cut short and left open.
        sent_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
        put_byte(1'b1, 13'(len), 8'($urandom));
        for (i = 1; i < sent_len; i++) put_byte(1'b0, random_amount(), 8'($urandom));
      end else if (pick < 60) begin
        if (fill > 0) peek_at(12'($urandom_range(0, fill - 1)));
        else peek_at(12'($urandom));
      end else if (pick < 75) begin
        if ($urandom_range(0, 4) == 0) advance_by(13'($urandom_range(0, fill)));
        else advance_by(13'($urandom_range(0, (fill < 6) ? fill : 6)));
      end else if (pick < 83) begin
        // Chunk length equal to the free space is refused; one less is taken.
        len = ($urandom_range(0, 1) == 0 || free_slots < 2) ? free_slots : free_slots - 1;
        put_byte(1'b1, 13'(len), 8'($urandom));
        sent_len = $urandom_range(0, 3);
        for (i = 0; i < sent_len; i++) put_byte(1'b0, random_amount(), 8'($urandom));
      end else if (pick < 85) begin
        clear_ring();
      end else if (pick < 90) begin
        peek_at(12'($urandom_range(fill, DEPTH - 1)));
      end else if (pick < 94) begin
        advance_by(13'($urandom_range(fill + 1, DEPTH)));
      end else begin
        send_request(make_req(brb_pkg::brb_func_t'($urandom_range(0, 3)),
                              brb_pkg::DATA_W'($urandom), 1'($urandom), random_amount(),
                              brb_pkg::OFFSET_W'($urandom)));
      end
    end
    release_input();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker. A result is taken at the next rising edge when valid and ready are
  // both high in the middle of the cycle; it is compared there against the oldest
  // expectation.
  always @(negedge clk) begin
    ring_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual data %0h status %0h count %0h",
                 $time, out_chan.read_data, out_chan.status, out_chan.valid_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", 32'(want.read_data), 32'(out_chan.read_data));
        check_field("status", 32'(want.status), 32'(out_chan.status));
        check_field("valid_count", 32'(want.count), 32'(out_chan.valid_count));
        check_field("not_empty", 32'(want.not_empty), 32'(out_chan.not_empty));
      end
    end
  end

  // Result side: ready follows its own pattern, switching between always ready, a coin
  // toss each cycle, and runs of stall cycles.
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned stall_left;
    out_chan.ready <= 1'b0;
    mode       = RX_OPEN;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      case (mode)
        RX_OPEN: begin
          out_chan.ready <= 1'b1;
        end
        RX_COIN: begin
          out_chan.ready <= 1'($urandom);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
          end
        end
      endcase
    end
  end

  // Watchdog against a block that stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[byte_ring_buffer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.func        <= brb_pkg::FUNC_PUT;
    in_chan.data_in     <= '0;
    in_chan.chunk_start <= 1'b0;
    in_chan.amount      <= '0;
    in_chan.offset      <= '0;
    ring_head  = '0;
    ring_tail  = '0;
    chunk_left = '0;
    chunk_drop = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring_errors();
    test_chunk_accept_reject();
    test_clear_and_space_limit();
    test_random_traffic(565);
    // The sender holds off until the block has answered every request so far.
    wait_drained();
    test_random_traffic(565);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[byte_ring_buffer_unit] OK");
    end else begin
      $display("[byte_ring_buffer_unit] ERROR");
    end
    $finish;
  end

endmodule
